@@ hw/rtl/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   // Binary magnitude and BCD sizes
   localparam int MAG_W       = 32;
   localparam int DIGITS      = 10;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int CNT_W       = $clog2(DIGITS + 1);

   // Shift-and-add-3 conversion: binary bits handled per pipeline stage
   localparam int STEP_BITS   = 4;
   localparam int NUM_STAGES  = MAG_W / STEP_BITS;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Payload carried through the conversion stages
   typedef struct packed {
      logic              neg;
      logic [BCD_W-1:0]  bcd;
      logic [MAG_W-1:0]  bin;
   } dab_type;

   // Payload after digit alignment: most significant digit in the top nibble
   typedef struct packed {
      logic              neg;
      logic [BCD_W-1:0]  digits;
      logic [CNT_W-1:0]  count;
   } aln_type;

endpackage

@@ hw/rtl/sitda_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One pipeline stage of the binary to BCD conversion: shifts STEP_BITS binary
// bits into the BCD accumulator, with the add-3 correction before each shift.
// ----------------------------------------------------------------------------
module sitda_dabble_stage
   import sitda_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  dab_type in_data,
   output logic    out_valid,
   output dab_type out_data
);

   logic    valid_ff;
   dab_type data_ff;
   dab_type data_in;

   // Shift-and-add-3 over this stage's bits
   always_comb begin
      data_in = in_data;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (data_in.bcd[4*d +: 4] >= 4'd5) begin
               data_in.bcd[4*d +: 4] = data_in.bcd[4*d +: 4] + 4'd3;
            end
         end
         {data_in.bcd, data_in.bin} = {data_in.bcd, data_in.bin} << 1;
      end
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/sitda_align.sv @@
// ----------------------------------------------------------------------------
// sitda_align
// Counts the significant digits of the BCD value and shifts them so that the
// leading digit sits in the top nibble. Zero counts as one digit.
// ----------------------------------------------------------------------------
module sitda_align
   import sitda_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  dab_type in_data,
   output logic    out_valid,
   output aln_type out_data
);

   logic             valid_ff;
   aln_type          data_ff;
   aln_type          data_in;
   logic [CNT_W-1:0] shamt;

   // Highest nonzero digit gives the count
   always_comb begin
      data_in.neg   = in_data.neg;
      data_in.count = CNT_W'(1);
      for (int d = 1; d < DIGITS; d++) begin
         if (in_data.bcd[4*d +: 4] != 4'd0) begin
            data_in.count = CNT_W'(d + 1);
         end
      end
      shamt          = CNT_W'(DIGITS) - data_in.count;
      data_in.digits = in_data.bcd << {shamt, 2'b00};
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/sitda_serializer.sv @@
// ----------------------------------------------------------------------------
// sitda_serializer
// Holds one aligned number and sends its text one character per response:
// the sign first when negative, then the digits from the most significant.
// ----------------------------------------------------------------------------
module sitda_serializer
   import sitda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  aln_type    in_data,
   output logic       load,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_character,
   output logic       rsp_last
);

   logic             ser_valid_ff, ser_valid_in;
   logic             ser_neg_ff, ser_neg_in;
   logic [BCD_W-1:0] ser_digits_ff, ser_digits_in;
   logic [CNT_W-1:0] ser_left_ff, ser_left_in;
   logic             rsp_accept;
   logic             final_char;

   assign rsp_accept = ser_valid_ff && !rsp_stall;
   assign final_char = !ser_neg_ff && (ser_left_ff == CNT_W'(1));
   // Take the next number when empty or when the final character goes out
   assign load       = in_valid && (!ser_valid_ff || (rsp_accept && final_char));

   // Next state
   always_comb begin
      ser_valid_in  = ser_valid_ff;
      ser_neg_in    = ser_neg_ff;
      ser_digits_in = ser_digits_ff;
      ser_left_in   = ser_left_ff;
      if (load) begin
         ser_valid_in  = 1'b1;
         ser_neg_in    = in_data.neg;
         ser_digits_in = in_data.digits;
         ser_left_in   = in_data.count;
      end else if (rsp_accept) begin
         if (ser_neg_ff) begin
            ser_neg_in = 1'b0;
         end else if (final_char) begin
            ser_valid_in = 1'b0;
         end else begin
            ser_digits_in = ser_digits_ff << 4;
            ser_left_in   = ser_left_ff - CNT_W'(1);
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      ser_neg_ff    <= ser_neg_in;
      ser_digits_ff <= ser_digits_in;
      ser_left_ff   <= ser_left_in;
   end

   // Character select
   assign rsp_valid     = ser_valid_ff;
   assign rsp_character = ser_neg_ff ? CHAR_MINUS
                                     : (CHAR_ZERO | {4'h0, ser_digits_ff[BCD_W-1 -: 4]});
   assign rsp_last      = final_char;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per response, most significant first, with last set on the final one.
// ----------------------------------------------------------------------------
// A request enters an input register that takes the magnitude, passes eight
// shift-and-add-3 stages of four bits each and an alignment stage, and then
// reaches the output serializer. The serializer sends one character per cycle
// while rsp_stall is low; a number's text has 1 to 11 characters ('-' plus up
// to ten digits). New requests are taken every cycle while the pipeline has
// room; the serializer's character rate sets the sustained throughput.
// Negative values start with '-', zero gives "0", and -2147483648 gives
// "-2147483648".
module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [31:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);

   logic                    stage_valid [0:NUM_STAGES];
   dab_type                 stage_data  [0:NUM_STAGES];
   logic                    in_valid_ff;
   dab_type                 in_data_ff;
   dab_type                 in_data_in;
   logic                    aln_valid;
   aln_type                 aln_data;
   logic                    ser_load;
   logic                    advance;

   // Pipeline moves when its last stage is empty or hands over to the serializer
   assign advance   = !aln_valid || ser_load;
   assign req_stall = !advance;

   // Input register: sign and magnitude
   always_comb begin
      in_data_in.neg = req_value[MAG_W-1];
      in_data_in.bin = req_value[MAG_W-1] ? (MAG_W'(0) - MAG_W'(req_value))
                                          : MAG_W'(req_value);
      in_data_in.bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff <= in_data_in;
      end
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_data[0]  = in_data_ff;

   // Binary to BCD conversion stages
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_dabble
      sitda_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // Digit count and alignment
   sitda_align u_align (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (stage_valid[NUM_STAGES]),
      .in_data   (stage_data[NUM_STAGES]),
      .out_valid (aln_valid),
      .out_data  (aln_data)
   );

   // Character output
   sitda_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (aln_valid),
      .in_data       (aln_data),
      .load          (ser_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // A sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

   // The digit after a sign is a nonzero leading digit
   a_after_minus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_character == CHAR_MINUS) |=>
      rsp_valid && (rsp_character != CHAR_ZERO) && (rsp_character != CHAR_MINUS))
      else $error("bad character after minus sign");

   // Requests are held back only when the alignment stage is occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> aln_valid)
      else $error("request stalled with empty pipeline end");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the signed integer to decimal ASCII converter. Each request's value
// is turned into its expected character sequence by a local model. Every
// response is matched against the oldest expected character, field by field.
// The test runs directed corner values and then random values, first over the
// full 32-bit range and then spread across text lengths. The random values run
// under three request/response idle/stall mixes, the directed ones in the first.
// ----------------------------------------------------------------------------
module testbench
   import sitda_pkg::*;
();

   localparam int unsigned DECIMAL_RADIX = 10;
   localparam int          SETTLE_CYCLES = 16;

   // One expected response character, tagged with the value that caused it
   typedef struct {
      logic [7:0]         character;
      logic               is_last;
      logic signed [31:0] source;
   } text_char_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_character;
   logic              rsp_last;

   text_char_type expected_text[$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   signed_int_to_decimal_ascii u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #(10_000_000);
      $display("FAIL signed_int_to_decimal_ascii");
      $finish;
   end

   // One line per mismatch
   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Queue the decimal text of one value: optional '-', digits MSD first
   function automatic void predict_decimal_text(input logic signed [31:0] value);
      logic [31:0]   magnitude;
      logic [7:0]    digits[$];
      text_char_type entry;
      magnitude = value[31] ? (32'd0 - value) : value;
      do begin
         digits.push_front(CHAR_ZERO + 8'(magnitude % DECIMAL_RADIX));
         magnitude = magnitude / DECIMAL_RADIX;
      end while (magnitude != 0);
      entry.source = value;
      if (value[31]) begin
         entry.character = CHAR_MINUS;
         entry.is_last   = 1'b0;
         expected_text.push_back(entry);
      end
      foreach (digits[i]) begin
         entry.character = digits[i];
         entry.is_last   = (i == digits.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // Send one request; valid is raised or held at the falling edge only
   task automatic send_value(input logic signed [31:0] value);
      bit accepted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !req_stall;
      end
      predict_decimal_text(value);
   endtask

   // Drop valid and wait for every expected character to come back
   task automatic wait_text_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each accepted response with the oldest expected character
   always @(posedge clock) begin : check_characters
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                      rsp_character, rsp_last));
         end else begin
            want = expected_text.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("value %0d: character 0x%02h, want 0x%02h",
                                         want.source, rsp_character, want.character));
            if (rsp_last !== want.is_last)
               report_mismatch($sformatf("value %0d: last %0b, want %0b on 0x%02h",
                                         want.source, rsp_last, want.is_last,
                                         want.character));
         end
      end
   end

   // Zero, single digits, decade edges, both extremes and alternating bits
   task automatic test_directed_values();
      logic signed [31:0] corner_values[] = '{
         32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
         32'sd99, 32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000,
         -32'sd1000000000, 32'sd1000000001, 32'sd123456789, -32'sd987654321,
         32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'h5555_5555,
         32'hAAAA_AAAA
      };
      foreach (corner_values[i]) send_value(corner_values[i]);
      wait_text_drained();
   endtask

   // Uniform 32-bit values: every input bit toggles, mostly long text
   task automatic test_full_range_values(input int count);
      repeat (count) send_value($urandom);
      wait_text_drained();
   endtask

   // Pick a digit count first so short and long text both show up often
   task automatic test_digit_length_values(input int count);
      int          num_digits;
      longint      low_mag;
      longint      high_mag;
      logic [31:0] magnitude;
      bit          negative;
      repeat (count) begin
         num_digits = $urandom_range(10, 1);
         negative   = $urandom_range(1);
         low_mag    = 1;
         repeat (num_digits - 1) low_mag = low_mag * DECIMAL_RADIX;
         high_mag   = low_mag * DECIMAL_RADIX - 1;
         if (num_digits == 1) low_mag = 0;
         // magnitude 2^31 only fits as a negative value
         if (high_mag > 64'd2147483647)
            high_mag = negative ? 64'd2147483648 : 64'd2147483647;
         magnitude = $urandom_range(32'(high_mag), 32'(low_mag));
         send_value(negative ? 32'(32'd0 - magnitude) : magnitude);
      end
      wait_text_drained();
   endtask

   // Main sequence
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender mostly busy, receiver mostly stalled
      send_idle_pct  = 7;
      recv_stall_pct = 87;
      test_directed_values();
      test_full_range_values(35);
      test_digit_length_values(35);

      // Sender mostly idle, receiver mostly ready
      send_idle_pct  = 87;
      recv_stall_pct = 7;
      test_full_range_values(35);
      test_digit_length_values(35);

      // Full rate on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_full_range_values(35);
      test_digit_length_values(35);

      if (error_count == 0) begin
         $display("PASS signed_int_to_decimal_ascii");
      end else begin
         $display("FAIL signed_int_to_decimal_ascii");
      end
      $finish;
   end

endmodule
